FILE: hdl/nma_pkg.sv
package nma_pkg;

  // Fixed field widths of the streaming channels and the configuration port.
  localparam int DATA_W    = 16;
  localparam int MODE_W    = 3;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = 3;

  // Activation mode codes. Codes above MODE_IDENT behave as identity.
  localparam logic [MODE_W-1:0] MODE_SIGMOID = 3'd0;
  localparam logic [MODE_W-1:0] MODE_TANH    = 3'd1;
  localparam logic [MODE_W-1:0] MODE_RELU    = 3'd2;
  localparam logic [MODE_W-1:0] MODE_ONE     = 3'd3;
  localparam logic [MODE_W-1:0] MODE_IDENT   = 3'd4;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE = 1'b1;

  typedef logic signed [DATA_W-1:0] fx_t;

  // One finished neuron sum on its way from the front to the back.
  typedef struct packed {
    fx_t  x;
    logic sat;
    logic hold;
  } nma_entry_t;

endpackage

FILE: hdl/nma_if.sv
interface nma_in_if import nma_pkg::*; ();
  logic valid;
  logic ready;
  fx_t  upstream_act;
  fx_t  weight;
  logic last;

  modport source (output valid, output upstream_act, output weight, output last,
                  input ready);
  modport sink   (input valid, input upstream_act, input weight, input last,
                  output ready);
endinterface

interface nma_out_if import nma_pkg::*; ();
  logic valid;
  logic ready;
  fx_t  sum_x;
  fx_t  out_y;
  fx_t  out_deriv;
  logic saturated;

  modport source (output valid, output sum_x, output out_y, output out_deriv,
                  output saturated, input ready);
  modport sink   (input valid, input sum_x, input out_y, input out_deriv,
                  input saturated, output ready);
endinterface

FILE: hdl/nma_front.sv
module nma_front import nma_pkg::*; #(
  parameter int FRAC_BITS = 12,
  parameter int ACC_WIDTH = 40
) (
  input  logic       clk,
  input  logic       rst_n,
  nma_in_if.sink     in_ch,
  input  logic       enable,
  output logic       push_valid,
  input  logic       push_ready,
  output nma_entry_t push_data
);

  localparam int SUM_W = ACC_WIDTH - FRAC_BITS;

  logic                        valid_r;
  logic                        last_r;
  logic signed [2*DATA_W-1:0]  prod_r;
  logic [ACC_WIDTH-1:0]        acc_r;

  logic                        advance;
  logic                        accept;
  logic [ACC_WIDTH-1:0]        acc_sum;
  logic signed [SUM_W-1:0]     scaled;
  logic                        sat_hi;
  logic                        sat_lo;
  fx_t                         x_clamp;

  // The product stage moves on unless it holds a last pair and the queue is full.
  assign advance     = valid_r && (!last_r || push_ready);
  assign in_ch.ready = !valid_r || advance;
  assign accept      = in_ch.valid && in_ch.ready;

  always_comb begin
    acc_sum = acc_r + ACC_WIDTH'(prod_r);
    scaled  = $signed(acc_sum[ACC_WIDTH-1:FRAC_BITS]);
    sat_hi  = !scaled[SUM_W-1] && (|scaled[SUM_W-2:DATA_W-1]);
    sat_lo  = scaled[SUM_W-1] && !(&scaled[SUM_W-2:DATA_W-1]);
    if (sat_hi) begin
      x_clamp = {1'b0, {(DATA_W-1){1'b1}}};
    end else if (sat_lo) begin
      x_clamp = {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      x_clamp = scaled[DATA_W-1:0];
    end
  end

  assign push_valid     = advance && last_r;
  assign push_data.x    = x_clamp;
  assign push_data.sat  = sat_hi || sat_lo;
  assign push_data.hold = !enable;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      acc_r   <= '0;
    end else begin
      if (in_ch.ready) begin
        valid_r <= accept;
      end
      if (advance && enable) begin
        acc_r <= last_r ? '0 : acc_sum;
      end
    end
    if (accept) begin
      prod_r <= in_ch.upstream_act * in_ch.weight;
      last_r <= in_ch.last;
    end
  end

endmodule

FILE: hdl/nma_queue.sv
module nma_queue import nma_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push_valid,
  output logic       push_ready,
  input  nma_entry_t push_data,
  output logic       pop_valid,
  input  logic       pop_ready,
  output nma_entry_t pop_data
);

  localparam int DEPTH = 2;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  nma_entry_t       slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  logic do_push;
  logic do_pop;

  assign push_ready = count_r != CNT_W'(DEPTH);
  assign pop_valid  = count_r != '0;
  assign pop_data   = slot_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

FILE: hdl/nma_back.sv
module nma_back import nma_pkg::*; #(
  parameter int FRAC_BITS   = 12,
  parameter int TABLE_DEPTH = 256
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [MODE_W-1:0] mode,
  input  logic              pop_valid,
  output logic              pop_ready,
  input  nma_entry_t        pop_data,
  nma_out_if.source         out_ch
);

  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int POS_W = DATA_W + IDX_W;
  localparam int SH_T  = FRAC_BITS + 3;
  localparam int SH_S  = FRAC_BITS + 4;
  localparam int REM_W = SH_S;
  localparam int IP_W  = 17 + REM_W + 1;
  localparam int W     = 18;
  localparam int DP_W  = 2 * W;
  localparam int ONE   = 1 << FRAC_BITS;
  localparam logic signed [W-1:0] ONE_S = W'(ONE);

  // Table of tanh(8*i/TABLE_DEPTH), built from an exp series in Q30.
  localparam longint unsigned Q30    = 64'd1 << 30;
  localparam longint unsigned STEP_H = (64'd16 << 30) / TABLE_DEPTH;
  localparam longint unsigned ONE64  = 64'd1 << FRAC_BITS;

  typedef logic [TABLE_DEPTH-1:0][DATA_W-1:0] curve_arr_t;

  // Unsigned long division, used only while the table is built at elaboration.
  function automatic longint unsigned div_u64(longint unsigned n, longint unsigned d);
    longint unsigned quo;
    longint unsigned rest;
    quo  = '0;
    rest = '0;
    for (int b = 63; b >= 0; b--) begin
      rest = {rest[62:0], n[b]};
      if (rest >= d) begin
        rest   = rest - d;
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  function automatic curve_arr_t build_curve();
    curve_arr_t      tab;
    longint unsigned term;
    longint unsigned q;
    longint unsigned e;
    longint unsigned num;
    longint unsigned den;
    tab  = '0;
    term = Q30;
    q    = Q30;
    e    = Q30;
    for (int k = 1; k <= 12; k++) begin
      term = div_u64((term * STEP_H) >> 30, 64'(k));
      if ((k & 1) != 0) begin
        q = q - term;
      end else begin
        q = q + term;
      end
    end
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      num    = Q30 - e;
      den    = Q30 + e;
      tab[i] = DATA_W'(div_u64(num * ONE64 + (den >> 1), den));
      e      = (e * q + (Q30 >> 1)) >> 30;
    end
    return tab;
  endfunction

  localparam curve_arr_t CURVE = build_curve();

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOOK,
    S_INTERP,
    S_ACT,
    S_DMUL,
    S_DONE
  } state_t;

  state_t                  state_r;
  fx_t                     x_r;
  fx_t                     y_r;
  logic                    sat_r;
  logic                    beyond_r;
  logic [DATA_W-1:0]       lo_r;
  logic [DATA_W-1:0]       hi_r;
  logic [REM_W-1:0]        rem_r;
  logic signed [IP_W-1:0]  ip_r;
  logic signed [DP_W-1:0]  dp_r;
  fx_t                     held_x_r;
  fx_t                     held_y_r;
  logic                    out_valid_r;
  fx_t                     out_x_r;
  fx_t                     out_y_r;
  fx_t                     out_d_r;
  logic                    out_sat_r;

  logic                    is_sig;
  logic [DATA_W-1:0]       mag;
  logic [POS_W-1:0]        pos;
  logic [POS_W-1:0]        idx_full;
  logic [POS_W-1:0]        idx_next;
  logic [REM_W-1:0]        rem;
  logic                    beyond;
  logic                    hi_in;
  logic [IDX_W-1:0]        idx_lo;
  logic [IDX_W-1:0]        idx_hi;
  logic [DATA_W-1:0]       lo_val;
  logic [DATA_W-1:0]       hi_val;
  logic signed [16:0]      diff;
  logic signed [IP_W-1:0]  ip;
  logic signed [W-1:0]     frac;
  logic signed [W-1:0]     r_val;
  logic signed [W-1:0]     t_val;
  logic signed [W-1:0]     sig_val;
  fx_t                     y_val;
  logic signed [W-1:0]     y_ext;
  logic signed [W-1:0]     opb;
  logic signed [DP_W-1:0]  dp;
  fx_t                     d_val;
  logic                    out_free;

  assign is_sig = mode == MODE_SIGMOID;

  // Table position from |x|: integer part indexes, remainder interpolates.
  always_comb begin
    mag      = x_r[DATA_W-1] ? DATA_W'(-x_r) : DATA_W'(x_r);
    pos      = POS_W'(mag) * POS_W'(TABLE_DEPTH);
    idx_full = is_sig ? (pos >> SH_S) : (pos >> SH_T);
    rem      = is_sig ? REM_W'(pos[SH_S-1:0]) : REM_W'(pos[SH_T-1:0]);
    beyond   = idx_full >= POS_W'(TABLE_DEPTH);
    idx_next = idx_full + 1'b1;
    hi_in    = idx_next < POS_W'(TABLE_DEPTH);
    idx_lo   = beyond ? '0 : idx_full[IDX_W-1:0];
    idx_hi   = hi_in ? idx_next[IDX_W-1:0] : '0;
    lo_val   = CURVE[idx_lo];
    hi_val   = hi_in ? CURVE[idx_hi] : DATA_W'(ONE);
  end

  always_comb begin
    diff = $signed({1'b0, hi_r}) - $signed({1'b0, lo_r});
    ip   = diff * $signed({1'b0, rem_r});
  end

  // Floored interpolation, sign mirror and the activation itself.
  always_comb begin
    frac    = is_sig ? W'(ip_r >>> SH_S) : W'(ip_r >>> SH_T);
    r_val   = beyond_r ? ONE_S : ($signed({2'b00, lo_r}) + frac);
    t_val   = x_r[DATA_W-1] ? -r_val : r_val;
    sig_val = (ONE_S + t_val) >>> 1;
    case (mode)
      MODE_SIGMOID: y_val = DATA_W'(sig_val);
      MODE_TANH:    y_val = DATA_W'(t_val);
      MODE_RELU:    y_val = (x_r > 0) ? x_r : '0;
      MODE_ONE:     y_val = DATA_W'(ONE);
      MODE_IDENT:   y_val = x_r;
      default:      y_val = x_r;
    endcase
  end

  always_comb begin
    y_ext = W'(y_r);
    opb   = is_sig ? (ONE_S - y_ext) : y_ext;
    dp    = y_ext * opb;
  end

  always_comb begin
    case (mode)
      MODE_SIGMOID: d_val = DATA_W'(dp_r >>> FRAC_BITS);
      MODE_TANH:    d_val = DATA_W'(DP_W'(ONE_S) - (dp_r >>> FRAC_BITS));
      MODE_RELU:    d_val = (x_r > 0) ? DATA_W'(ONE) : '0;
      MODE_ONE:     d_val = '0;
      MODE_IDENT:   d_val = DATA_W'(ONE);
      default:      d_val = DATA_W'(ONE);
    endcase
  end

  assign pop_ready = state_r == S_IDLE;
  assign out_free  = !out_valid_r || out_ch.ready;

  assign out_ch.valid     = out_valid_r;
  assign out_ch.sum_x     = out_x_r;
  assign out_ch.out_y     = out_y_r;
  assign out_ch.out_deriv = out_d_r;
  assign out_ch.saturated = out_sat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      held_x_r    <= '0;
      held_y_r    <= '0;
    end else begin
      if (state_r == S_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (pop_valid) begin
            if (pop_data.hold) begin
              x_r     <= held_x_r;
              y_r     <= held_y_r;
              sat_r   <= 1'b0;
              state_r <= S_DMUL;
            end else begin
              x_r     <= pop_data.x;
              sat_r   <= pop_data.sat;
              state_r <= S_LOOK;
            end
          end
        end
        S_LOOK: begin
          lo_r     <= lo_val;
          hi_r     <= hi_val;
          rem_r    <= rem;
          beyond_r <= beyond;
          state_r  <= S_INTERP;
        end
        S_INTERP: begin
          ip_r    <= ip;
          state_r <= S_ACT;
        end
        S_ACT: begin
          y_r      <= y_val;
          held_x_r <= x_r;
          held_y_r <= y_val;
          state_r  <= S_DMUL;
        end
        S_DMUL: begin
          dp_r    <= dp;
          state_r <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            out_x_r     <= x_r;
            out_y_r     <= y_r;
            out_d_r     <= d_val;
            out_sat_r   <= sat_r;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: hdl/neuron_mac_activation.sv
// A last pair passes the product register, the queue, back end states look, interp,
// act and dmul (only dmul when disabled) and the output register, where its result
// waits. One (activation, weight) pair per cycle enters the multiply-accumulate
// unless a last pair waits on a full queue; the back end takes a sum only when idle.
// Reset (synchronous, rst_n low): accumulator, held x and y cleared, mode sigmoid,
// enable set, the queue empty. The curve table is constant logic and needs no fill.
module neuron_mac_activation import nma_pkg::*; #(
  parameter int FRAC_BITS   = 12,
  parameter int ACC_WIDTH   = 40,
  parameter int TABLE_DEPTH = 256
) (
  input  logic                 clk,
  input  logic                 rst_n,
  nma_in_if.sink               in_ch,
  nma_out_if.source            out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_wdata
);

  // Configuration registers. They are to be written only while the block is idle
  // (up to the user), so the front and back read them live without any snapshot.
  logic [MODE_W-1:0] mode_r;
  logic              enable_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_SIGMOID;
      enable_r <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MODE:   mode_r   <= cfg_wdata[MODE_W-1:0];
        CFG_ENABLE: enable_r <= cfg_wdata[0];
        default:    ;
      endcase
    end
  end

  // The front end registers each product and, while enabled, adds it into the
  // wrapping accumulator. On a last pair it scales the sum back to the output
  // format, saturates it and hands it to the queue; a disabled neuron hands
  // over a marker that tells the back end to replay the held x and y instead.
  logic       push_valid;
  logic       push_ready;
  nma_entry_t push_data;

  nma_front #(
    .FRAC_BITS (FRAC_BITS),
    .ACC_WIDTH (ACC_WIDTH)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .enable     (enable_r),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  // A two-entry queue lets the accumulator keep taking pairs of the next
  // neuron while the back end is still evaluating the previous one.
  logic       pop_valid;
  logic       pop_ready;
  nma_entry_t pop_data;

  nma_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  // The back end steps through table lookup, interpolation, activation and
  // the derivative product (for a hold marker only the last), then loads the
  // output register. Sigmoid reuses the tanh table at half the slope.
  nma_back #(
    .FRAC_BITS   (FRAC_BITS),
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .mode      (mode_r),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .out_ch    (out_ch)
  );

endmodule

FILE: tb/sv/testbench.sv
module testbench;
  import nma_pkg::*;

  // Fixed-point format and sizes that the block is built with.
  localparam int FRAC   = 12;
  localparam int ACC_W  = 40;
  localparam int TDEPTH = 256;
  localparam int ONE    = 1 << FRAC;
  localparam longint unsigned Q30 = 64'd1 << 30;

  // Mode codes above MODE_IDENT have no name in the package; they act as identity.
  localparam logic [MODE_W-1:0] MODE_SPARE_TOP = '1;

  // Cycles to let pass once the last result has arrived, so that the wait also covers
  // pairs that make no result.
  localparam int SETTLE_CYCLES = 16;

  typedef struct packed {
    fx_t  act;
    fx_t  wt;
    logic last;
  } synapse_t;

  typedef struct packed {
    fx_t  sum_x;
    fx_t  y;
    fx_t  deriv;
    logic sat;
  } neuron_result_t;

  logic clk = 1'b0;
  logic rst_n;

  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DAT_W-1:0] cfg_wdata;

  nma_in_if  in_ch ();
  nma_out_if out_ch ();

  neuron_mac_activation dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #10 clk = ~clk;

  // Synapse pairs waiting to be offered, and the results the block owes us.
  synapse_t       synapse_queue[$];
  neuron_result_t awaited_results[$];

  // Counting queued and transferred pairs tells the stimulus when the input side
  // is truly empty, without relying on the order of events inside a time step.
  int pairs_queued   = 0;
  int pairs_accepted = 0;
  int mismatch_count = 0;

  // Percentage of cycles in which each side holds back.
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  // Our own copy of the neuron: registers, accumulator, held outputs and the
  // tanh samples that sigmoid and tanh interpolate between.
  logic [MODE_W-1:0] act_mode;
  logic              neuron_enable;
  logic [ACC_W-1:0]  acc_reg;
  int                held_x;
  int                held_y;
  logic [15:0]       tanh_samples [TDEPTH];

  // The table holds tanh(8*i/TDEPTH) in Q4.12. It is built the way the hardware
  // constants were derived: exp(-h) from a 12-term series in Q30, then repeated
  // multiplication, so that every sample matches to the last bit.
  function automatic void build_tanh_samples();
    longint unsigned h, term, q, e, num, den;
    h    = (longint'(16) << 30) / TDEPTH;
    term = Q30;
    q    = Q30;
    e    = Q30;
    for (int k = 1; k <= 12; k++) begin
      term = ((term * h) >> 30) / k;
      if (k % 2 == 1) q -= term;
      else q += term;
    end
    for (int i = 0; i < TDEPTH; i++) begin
      num = Q30 - e;
      den = Q30 + e;
      tanh_samples[i] = 16'((num * ONE + den / 2) / den);
      e = (e * q + (Q30 >> 1)) >> 30;
    end
  endfunction

  // Interpolated tanh. The span is 8.0 for tanh itself and 16.0 when sigmoid
  // wants tanh(x/2). Past the last sample the curve meets 1.0; a falling segment
  // rounds its step up so the result is still floored.
  function automatic int tanh_interp(int x, longint span);
    longint mag, pos, idx, rem, lo, hi, r;
    mag = (x < 0) ? -longint'(x) : longint'(x);
    pos = mag * TDEPTH;
    idx = pos / span;
    rem = pos % span;
    if (idx >= TDEPTH) begin
      r = ONE;
    end else begin
      lo = tanh_samples[idx];
      hi = (idx + 1 < TDEPTH) ? longint'(tanh_samples[idx + 1]) : longint'(ONE);
      if (hi >= lo) r = lo + ((hi - lo) * rem) / span;
      else r = lo - (((lo - hi) * rem + span - 1) / span);
    end
    return (x < 0) ? -int'(r) : int'(r);
  endfunction

  function automatic int activation(logic [MODE_W-1:0] m, int x);
    case (m)
      MODE_SIGMOID: return (ONE + tanh_interp(x, longint'(16) << FRAC)) / 2;
      MODE_TANH:    return tanh_interp(x, longint'(8) << FRAC);
      MODE_RELU:    return (x > 0) ? x : 0;
      MODE_ONE:     return ONE;
      default:      return x;
    endcase
  endfunction

  // Derivative for the current mode; the products are floored back to Q4.12.
  function automatic int slope(logic [MODE_W-1:0] m, int x, int y);
    longint p;
    case (m)
      MODE_SIGMOID: begin
        p = longint'(y) * longint'(ONE - y);
        return int'(p >>> FRAC);
      end
      MODE_TANH: begin
        p = longint'(y) * longint'(y);
        return ONE - int'(p / ONE);
      end
      MODE_RELU: return (x > 0) ? ONE : 0;
      MODE_ONE:  return 0;
      default:   return ONE;
    endcase
  endfunction

  // One transferred pair. While enabled, its product goes into the wrapping
  // accumulator; on the last pair the sum is floored to Q4.12, clipped to 16 bits
  // and activated. While disabled, the accumulator is left alone and a last pair
  // just reports the held x and y. Only last pairs owe a result.
  function automatic void neuron_step(fx_t act, fx_t wt, logic last);
    longint         prod, sum_q;
    logic           clipped;
    neuron_result_t res;
    clipped = 1'b0;
    if (neuron_enable) begin
      prod    = longint'(act) * longint'(wt);
      acc_reg = acc_reg + prod[ACC_W-1:0];
      if (!last) return;
      sum_q = longint'($signed(acc_reg)) >>> FRAC;
      if (sum_q > 32767) begin
        sum_q   = 32767;
        clipped = 1'b1;
      end else if (sum_q < -32768) begin
        sum_q   = -32768;
        clipped = 1'b1;
      end
      held_x  = int'(sum_q);
      held_y  = activation(act_mode, held_x);
      acc_reg = '0;
    end else if (!last) begin
      return;
    end
    res = '{sum_x: fx_t'(held_x), y: fx_t'(held_y),
            deriv: fx_t'(slope(act_mode, held_x, held_y)), sat: clipped};
    awaited_results = {awaited_results, res};
  endfunction

  task automatic report_mismatch(string what, neuron_result_t got, neuron_result_t want);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("%0t %s: got x=%0d y=%0d d=%0d sat=%0b", $time, what,
               got.sum_x, got.y, got.deriv, got.sat);
      $display("    expected x=%0d y=%0d d=%0d sat=%0b",
               want.sum_x, want.y, want.deriv, want.sat);
    end
  endtask

  // Input driver. A pair that was offered is predicted at the edge where its
  // transfer happens. Valid gets at most one assignment per edge, so it never
  // glitches low between two back-to-back pairs.
  always @(posedge clk) begin
    synapse_t next_syn;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        neuron_step(in_ch.upstream_act, in_ch.weight, in_ch.last);
        pairs_accepted++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (synapse_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next_syn = synapse_queue.pop_front();
          in_ch.valid        <= 1'b1;
          in_ch.upstream_act <= next_syn.act;
          in_ch.weight       <= next_syn.wt;
          in_ch.last         <= next_syn.last;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor. Ready is drawn afresh every cycle; each transfer is checked
  // against the oldest awaited result, field by field.
  always @(posedge clk) begin
    neuron_result_t got, want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      if (out_ch.valid && out_ch.ready) begin
        got = '{sum_x: out_ch.sum_x, y: out_ch.out_y, deriv: out_ch.out_deriv,
                sat: out_ch.saturated};
        if (awaited_results.size() == 0) begin
          report_mismatch("result with nothing awaited", got, '0);
        end else begin
          want = awaited_results.pop_front();
          if (got.sum_x !== want.sum_x || got.y !== want.y ||
              got.deriv !== want.deriv || got.sat !== want.sat) begin
            report_mismatch("result mismatch", got, want);
          end
        end
      end
    end
  end

  task automatic queue_pair(fx_t act, fx_t wt, logic last);
    synapse_t syn;
    syn = '{act: act, wt: wt, last: last};
    synapse_queue = {synapse_queue, syn};
    pairs_queued++;
  endtask

  // Mostly moderate values so the sums land across the whole Q4.12 range, with
  // full-range words to exercise every bit and the corner values now and then.
  function automatic fx_t rand_fx();
    case ($urandom_range(9))
      0, 1, 2: return fx_t'($urandom);
      3: begin
        case ($urandom_range(3))
          0:       return 16'sh8000;
          1:       return 16'sh7FFF;
          2:       return 16'sh0000;
          default: return 16'shFFFF;
        endcase
      end
      default: return fx_t'(int'($urandom_range(24576)) - 12288);
    endcase
  endfunction

  // A well-formed neuron evaluation: some synapses, the bias pair marked last.
  task automatic queue_neuron(int synapses);
    for (int i = 0; i < synapses; i++) queue_pair(rand_fx(), rand_fx(), i == synapses - 1);
  endtask

  // Pause the sender until every queued pair has been transferred and every
  // awaited result has come back, then give the pipeline time to go quiet.
  task automatic settle();
    while (pairs_accepted != pairs_queued || awaited_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Register writes happen only after settle(), so the predictor can take the
  // new value at once.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    if (idx == CFG_MODE) act_mode = data;
    else neuron_enable = data[0];
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Only bit 0 of the enable register counts, so the upper bits get noise.
  task automatic set_enable(logic en);
    logic [CFG_DAT_W-1:0] data;
    data    = $urandom;
    data[0] = en;
    write_reg(CFG_ENABLE, data);
  endtask

  initial begin
    int budget, used, len;

    // Every input of the block has a known value before the first edge.
    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_index          = CFG_MODE;
    cfg_wdata          = '0;
    in_ch.valid        = 1'b0;
    in_ch.upstream_act = '0;
    in_ch.weight       = '0;
    in_ch.last         = 1'b0;
    out_ch.ready       = 1'b0;

    // Predictor state after reset: sigmoid, enabled, everything cleared.
    build_tanh_samples();
    act_mode      = MODE_SIGMOID;
    neuron_enable = 1'b1;
    acc_reg       = '0;
    held_x        = 0;
    held_y        = 0;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // First setting: sender mostly busy, receiver mostly stalled.
    send_idle_pct = 12;
    recv_idle_pct = 74;

    // Single-pair neurons at the corners of the sum: the largest product clips
    // high, the most negative one clips low, one times one gives exactly 1.0,
    // and a product of minus one lsb shows the floor.
    queue_pair(16'sh8000, 16'sh8000, 1'b1);
    queue_pair(16'sh7FFF, 16'sh8000, 1'b1);
    queue_pair(16'sh1000, 16'sh1000, 1'b1);
    queue_pair(16'shFFFF, 16'sh0001, 1'b1);
    queue_pair(16'sh0000, 16'sh0000, 1'b1);
    queue_pair(16'sh2000, 16'sh0800, 1'b0);
    queue_pair(16'shF000, 16'sh0400, 1'b0);
    queue_pair(16'sh1000, 16'shFE00, 1'b1);

    // Every mode code, the spare ones included, with a clipped sum and a mid-range
    // sum whose sign alternates. The last code leaves a negative held y behind.
    for (int m = 0; m < 8; m++) begin
      settle();
      write_reg(CFG_MODE, MODE_W'(m));
      queue_pair(16'sh8000, 16'sh8000, 1'b1);
      queue_pair(m[0] ? -16'sd10000 : 16'sd10000, 16'sh1000, 1'b1);
    end

    // A neuron left half done, then the neuron is disabled: its pairs must not
    // reach the accumulator, and a last pair reports the held values with the
    // derivative of whatever mode is current. A negative held y under sigmoid
    // gives a negative product to floor.
    queue_pair(16'sh2000, 16'sh1000, 1'b0);
    settle();
    write_reg(CFG_MODE, MODE_SIGMOID);
    set_enable(1'b0);
    queue_pair(16'sh1234, 16'sh5678, 1'b0);
    queue_pair(16'sh0100, 16'sh0100, 1'b1);
    settle();
    write_reg(CFG_MODE, MODE_TANH);
    queue_pair(16'sh7FFF, 16'sh7FFF, 1'b1);

    // Back on: the half-done neuron finishes unharmed.
    settle();
    set_enable(1'b1);
    queue_pair(16'sh1000, 16'sh1000, 1'b1);

    // Random neurons in blocks, one register setting per block. The first eight
    // blocks walk through all mode codes; every fourth block runs disabled and
    // is kept short. Each block starts from a drained pipeline, so the sender
    // also waits for every awaited result here.
    for (int blk = 0; blk < 12; blk++) begin
      settle();
      case (blk / 4)
        0: begin
          send_idle_pct = 12;
          recv_idle_pct = 74;
        end
        1: begin
          send_idle_pct = 74;
          recv_idle_pct = 12;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      write_reg(CFG_MODE, (blk < 8) ? MODE_W'(blk) : MODE_W'($urandom_range(7)));
      set_enable(blk % 4 != 3);
      budget = (blk % 4 == 3) ? 16 : 50;
      used   = 0;
      while (used < budget) begin
        len = $urandom_range(1, 6);
        queue_neuron(len);
        used += len;
      end
    end

    // Leave the block enabled at the end so the last register write is a
    // plain setting rather than the disabled corner.
    settle();
    write_reg(CFG_MODE, MODE_SPARE_TOP);
    set_enable(1'b1);
    queue_neuron(3);
    settle();

    if (mismatch_count == 0) begin
      $display("[neuron_mac_activation] OK");
    end else begin
      $display("[neuron_mac_activation] ERROR");
    end
    $finish;
  end

  // Watchdog: the slowest correct run stays far below this.
  initial begin
    #4000000;
    $display("[neuron_mac_activation] ERROR");
    $finish;
  end

endmodule

FILE: files.f
hdl/nma_pkg.sv
hdl/nma_if.sv
hdl/nma_front.sv
hdl/nma_queue.sv
hdl/nma_back.sv
hdl/neuron_mac_activation.sv
tb/sv/testbench.sv
